// ===== sv/mtsp_pkg.sv =====
// Shared types, constants and stage functions for the setup PIN pipeline.
package mtsp_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] PIN_SPAN = 32'd90000000;
	localparam logic [31:0] PIN_BASE = 32'd10000000;
	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic [26:0] FALLBACK_PIN = 27'd49368103;
	localparam logic [26:0] PIN_MIN = 27'd10000000;
	localparam logic [26:0] PIN_MAX = 27'd99999999;
	localparam int HASH_STAGES = 16;
	localparam int MAC_BYTES = 6;
	localparam int BCD_DIGITS = 8;
	localparam logic [7:0] SALT [10] = '{8'h48, 8'h55, 8'h4E, 8'h54, 8'h45,
		8'h52, 8'h2D, 8'h48, 8'h41, 8'h50};

	// one item as it travels down the pipeline
	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] h;
		logic [31:0] r;
		logic [26:0] pin;
		logic [26:0] rv;
		logic [31:0] bcd;
		logic        fb;
		logic        done;
		logic        weak_hit;
		logic [4:0]  tries;
	} item_t;

	// pipeline control shared by all parts
	typedef struct packed {
		logic en;
	} ctl_t;

	function automatic logic pin_is_weak(input logic [26:0] p);
		return p == 27'd11111111 || p == 27'd12345678 ||
			p == 27'd87654321 || p == 27'd55555555;
	endfunction

	// one FNV-1a byte: MAC bytes first, then the salt
	function automatic item_t hash_stage(input item_t a, input logic [3:0] i);
		item_t o;
		logic [7:0] b;
		logic [31:0] x;
		o = a;
		if (i < 4'(MAC_BYTES)) begin
			b = a.mac[8 * (5 - i) +: 8];
		end else begin
			b = SALT[i - 4'(MAC_BYTES)];
		end
		x = a.h ^ {24'd0, b};
		o.h = x * FNV_PRIME;
		return o;
	endfunction

	// one quarter of a try: two reduce steps in each of three phases, then commit and LCG
	function automatic item_t pick_stage(input item_t a, input logic [1:0] ph);
		item_t o;
		logic [31:0] r;
		logic [31:0] d;
		logic [26:0] p;
		int s;
		o = a;
		r = (ph == 2'd0) ? a.h : a.r;
		case (ph)
			2'd0, 2'd1, 2'd2: begin
				for (int k = 0; k < 2; k++) begin
					s = 5 - 2 * int'(ph) - k;
					d = PIN_SPAN << s;
					if (r >= d) begin
						r = r - d;
					end
				end
				o.r = r;
			end
			default: begin
				p = 27'(a.r + PIN_BASE);
				if (!a.done) begin
					o.pin = p;
					o.tries = 5'(a.tries + 5'd1);
					o.weak_hit = pin_is_weak(p);
					o.done = !pin_is_weak(p);
				end
				o.h = a.h * LCG_MUL + LCG_ADD;
			end
		endcase
		return o;
	endfunction

	// peel one decimal digit with a reciprocal multiply
	function automatic item_t bcd_stage(input item_t a, input logic [2:0] k);
		item_t o;
		logic [31:0] v;
		logic [63:0] prod;
		logic [28:0] q;
		logic [31:0] dg;
		o = a;
		v = (k == 3'd0) ? {5'd0, a.pin} : {5'd0, a.rv};
		prod = {32'd0, v} * 64'h0000_0000_CCCC_CCCD;
		q = prod[63:35];
		dg = v - ({3'd0, q} * 32'd10);
		o.rv = 27'(q);
		if (k == 3'd0) begin
			o.bcd = 32'd0;
		end
		o.bcd[4 * k +: 4] = dg[3:0];
		return o;
	endfunction

endpackage

// ===== sv/mac_to_setup_pin_derivation_top.sv =====
// Top level of the MAC to setup PIN pipeline.
//
//  channel | handshake           | payload
//  input   | in_valid / in_ready | mac_address, mac_valid
//  output  | out_valid/out_ready | pin_value, pin_bcd, used_fallback, weak_kept, tries_used
//
// One request enters per cycle while the pipeline is not frozen; each request
// passes through the hash, try and digit stages in that order.
// The last stage is the output register; while it holds an untaken result
// the whole pipeline freezes and in_ready is low.
// arst_n clears all valid bits; payload registers are not reset.
module mac_to_setup_pin_derivation_top #(
	parameter int MAX_TRIES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] mac_address,
	input  logic        mac_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [26:0] pin_value,
	output logic [31:0] pin_bcd,
	output logic        used_fallback,
	output logic        weak_kept,
	output logic [2:0]  tries_used
);

	mtsp_pkg::ctl_t  ctl;
	mtsp_pkg::item_t in_itm;
	mtsp_pkg::item_t h_itm;
	mtsp_pkg::item_t p_itm;
	mtsp_pkg::item_t b_itm;
	logic            h_vld;
	logic            p_vld;
	logic            b_vld;

	// stall only when the output holds an untaken result
	assign ctl.en = !b_vld || out_ready;
	assign in_ready = ctl.en;

	// seed the request; fallback requests start out done
	always_comb begin
		in_itm = '0;
		in_itm.mac = mac_address;
		in_itm.h = mtsp_pkg::FNV_BASIS;
		in_itm.pin = mtsp_pkg::FALLBACK_PIN;
		in_itm.fb = !mac_valid;
		in_itm.done = !mac_valid;
	end

	mtsp_hash u_hash (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_vld(in_valid && in_ready), .in_itm(in_itm),
		.out_vld(h_vld), .out_itm(h_itm)
	);

	mtsp_pick #(.MAX_TRIES(MAX_TRIES)) u_pick (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_vld(h_vld), .in_itm(h_itm),
		.out_vld(p_vld), .out_itm(p_itm)
	);

	mtsp_bcd u_bcd (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_vld(p_vld), .in_itm(p_itm),
		.out_vld(b_vld), .out_itm(b_itm)
	);

	assign out_valid = b_vld;
	assign pin_value = b_itm.pin;
	assign pin_bcd = b_itm.bcd;
	assign used_fallback = b_itm.fb;
	assign weak_kept = b_itm.weak_hit;
	assign tries_used = b_itm.tries[2:0];

`ifndef SYNTH
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("stall without held result");
	a_fb_pin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used_fallback |->
			pin_value == mtsp_pkg::FALLBACK_PIN && tries_used == 3'd0 && !weak_kept)
		else $error("fallback result malformed");
	a_pin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pin_value >= mtsp_pkg::PIN_MIN && pin_value <= mtsp_pkg::PIN_MAX)
		else $error("PIN out of range");
	a_tries: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !used_fallback && MAX_TRIES < 8 |-> tries_used != 3'd0)
		else $error("no candidate counted");
`endif

endmodule

// ===== sv/mtsp_hash.sv =====
// FNV-1a hash over MAC and salt, one byte per pipeline stage.
module mtsp_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  mtsp_pkg::ctl_t      ctl,
	input  logic                in_vld,
	input  mtsp_pkg::item_t     in_itm,
	output logic                out_vld,
	output mtsp_pkg::item_t     out_itm
);

	localparam int N = mtsp_pkg::HASH_STAGES;

	logic            vld_s [N + 1];
	mtsp_pkg::item_t itm_s [N + 1];

	assign vld_s[0] = in_vld;
	assign itm_s[0] = in_itm;

	for (genvar i = 0; i < N; i++) begin : g_st
		// advance valid with the stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i + 1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i + 1] <= vld_s[i];
			end
		end
		// hash one byte
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				itm_s[i + 1] <= mtsp_pkg::hash_stage(itm_s[i], 4'(i));
			end
		end
	end

	assign out_vld = vld_s[N];
	assign out_itm = itm_s[N];

endmodule

// ===== sv/mtsp_pick.sv =====
// Candidate PIN tries: reduce mod span, check weak list, step the LCG.
module mtsp_pick #(
	parameter int MAX_TRIES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtsp_pkg::ctl_t      ctl,
	input  logic                in_vld,
	input  mtsp_pkg::item_t     in_itm,
	output logic                out_vld,
	output mtsp_pkg::item_t     out_itm
);

	localparam int N = 4 * MAX_TRIES;

	logic            vld_s [N + 1];
	mtsp_pkg::item_t itm_s [N + 1];

	assign vld_s[0] = in_vld;
	assign itm_s[0] = in_itm;

	for (genvar i = 0; i < N; i++) begin : g_st
		// advance valid with the stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i + 1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i + 1] <= vld_s[i];
			end
		end
		// two reduce steps, or commit a candidate
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				itm_s[i + 1] <= mtsp_pkg::pick_stage(itm_s[i], 2'(i % 4));
			end
		end
	end

	assign out_vld = vld_s[N];
	assign out_itm = itm_s[N];

endmodule

// ===== sv/mtsp_bcd.sv =====
// Binary to packed BCD, one decimal digit per pipeline stage.
module mtsp_bcd (
	input  logic                clk,
	input  logic                arst_n,
	input  mtsp_pkg::ctl_t      ctl,
	input  logic                in_vld,
	input  mtsp_pkg::item_t     in_itm,
	output logic                out_vld,
	output mtsp_pkg::item_t     out_itm
);

	localparam int N = mtsp_pkg::BCD_DIGITS;

	logic            vld_s [N + 1];
	mtsp_pkg::item_t itm_s [N + 1];

	assign vld_s[0] = in_vld;
	assign itm_s[0] = in_itm;

	for (genvar i = 0; i < N; i++) begin : g_st
		// advance valid with the stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i + 1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i + 1] <= vld_s[i];
			end
		end
		// extract one digit
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				itm_s[i + 1] <= mtsp_pkg::bcd_stage(itm_s[i], 3'(i));
			end
		end
	end

	assign out_vld = vld_s[N];
	assign out_itm = itm_s[N];

endmodule

// ===== test/tb_mac_to_setup_pin_derivation_top.sv =====
// Testbench for the MAC to setup PIN pipeline: queued stimulus, scoreboard check.
`timescale 1ns / 100ps
module tb_mac_to_setup_pin_derivation_top;

	localparam int TRIES = 4;
	localparam int PIPE_LAT = 24 + 4 * TRIES;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] SALT_BYTES [10] = '{8'h48, 8'h55, 8'h4E, 8'h54, 8'h45,
		8'h52, 8'h2D, 8'h48, 8'h41, 8'h50};

	typedef struct {
		logic [47:0] mac;
		logic        ok;
	} request_t;

	typedef struct {
		logic [26:0] pin;
		logic [31:0] bcd;
		logic        fb;
		logic        all_weak;
		logic [2:0]  tries;
	} pin_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [47:0] mac_address;
	logic        mac_valid;
	logic        out_valid;
	logic        out_ready;
	logic [26:0] pin_value;
	logic [31:0] pin_bcd;
	logic        used_fallback;
	logic        weak_kept;
	logic [2:0]  tries_used;

	request_t    pending_reqs[$];
	pin_result_t expected_pins[$];
	int          mismatches;
	int          results_seen;
	int          fallbacks_seen;
	int          weak_seen;
	int          cycles;
	bit          calm;
	bit          hold_off;
	int          hold_left;
	bit          stim_done;

	mac_to_setup_pin_derivation_top #(.MAX_TRIES(TRIES)) dut (.*);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] bcd_of(input logic [31:0] v);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			r[4 * k +: 4] = 4'(v % 10);
			v = v / 10;
		end
		return r;
	endfunction

	function automatic logic weak_pin(input logic [31:0] p);
		return p == 32'd11111111 || p == 32'd12345678 || p == 32'd87654321 ||
			p == 32'd55555555;
	endfunction

	// derive the PIN a MAC should map to
	function automatic pin_result_t derive_pin(input request_t q);
		pin_result_t e;
		logic [31:0] h;
		logic [31:0] p;
		int n;
		e.fb = 1'b0;
		e.all_weak = 1'b0;
		if (!q.ok) begin
			e.pin = mtsp_pkg::FALLBACK_PIN;
			e.bcd = 32'h49368103;
			e.fb = 1'b1;
			e.tries = '0;
			return e;
		end
		h = mtsp_pkg::FNV_BASIS;
		for (int i = 5; i >= 0; i--)
			h = (h ^ {24'd0, q.mac[8 * i +: 8]}) * mtsp_pkg::FNV_PRIME;
		for (int i = 0; i < 10; i++)
			h = (h ^ {24'd0, SALT_BYTES[i]}) * mtsp_pkg::FNV_PRIME;
		p = 0;
		n = 0;
		for (int i = 0; i < TRIES; i++) begin
			p = h % mtsp_pkg::PIN_SPAN + mtsp_pkg::PIN_BASE;
			n++;
			e.all_weak = weak_pin(p);
			if (!e.all_weak)
				break;
			h = h * mtsp_pkg::LCG_MUL + mtsp_pkg::LCG_ADD;
		end
		e.pin = p[26:0];
		e.bcd = bcd_of(p);
		e.tries = 3'(n);
		return e;
	endfunction

	function automatic request_t rand_req();
		request_t q;
		q.mac = 48'({$urandom, $urandom});
		q.ok = ($urandom_range(0, 9) != 0);
		return q;
	endfunction

	// reset and cycle watchdog
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// drive requests from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mac_address <= '0;
			mac_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				void'(pending_reqs.pop_front());
			if (in_valid && !in_ready) begin
				// hold until accepted
			end else if ((in_valid && in_ready ? pending_reqs.size() > 0
					: pending_reqs.size() > 0) && (calm || $urandom_range(0, 99) >= 20)) begin
				in_valid <= 1'b1;
				mac_address <= pending_reqs[0].mac;
				mac_valid <= pending_reqs[0].ok;
				expected_pins.push_back(derive_pin(pending_reqs[0]));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_off && hold_left == 0) begin
			hold_left <= 300;
			out_ready <= 1'b0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (hold_left == 1)
				hold_left <= 0;
			out_ready <= calm || $urandom_range(0, 99) >= 20;
		end
	end

	// check results against the oldest expectation
	always @(posedge clk) begin
		pin_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (used_fallback)
				fallbacks_seen <= fallbacks_seen + 1;
			if (weak_kept)
				weak_seen <= weak_seen + 1;
			if (expected_pins.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result pin=%0d", pin_value);
			end else begin
				e = expected_pins.pop_front();
				if (pin_value !== e.pin || pin_bcd !== e.bcd || used_fallback !== e.fb ||
						weak_kept !== e.all_weak || tries_used !== e.tries) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("mismatch exp pin=%0d bcd=%h fb=%b wk=%b tr=%0d",
							e.pin, e.bcd, e.fb, e.all_weak, e.tries);
						$display("         got pin=%0d bcd=%h fb=%b wk=%b tr=%0d",
							pin_value, pin_bcd, used_fallback, weak_kept, tries_used);
					end
				end
			end
		end
	end

	// fill the queue in phases
	initial begin
		request_t q;
		mismatches = 0;
		results_seen = 0;
		fallbacks_seen = 0;
		weak_seen = 0;
		cycles = 0;
		calm = 1'b0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		@(posedge arst_n);
		// directed: field extremes, fallback, walking bits
		q.ok = 1'b1;
		q.mac = '0; pending_reqs.push_back(q);
		q.mac = '1; pending_reqs.push_back(q);
		q.mac = 48'hAAAA_AAAA_AAAA; pending_reqs.push_back(q);
		q.mac = 48'h5555_5555_5555; pending_reqs.push_back(q);
		q.mac = 48'h0123_4567_89AB; pending_reqs.push_back(q);
		q.ok = 1'b0;
		q.mac = '1; pending_reqs.push_back(q);
		q.mac = '0; pending_reqs.push_back(q);
		for (int i = 0; i < 12; i++) begin
			q.mac = 48'h1 << (4 * i);
			q.ok = i[0];
			pending_reqs.push_back(q);
		end
		// receiver stalls for a long time while the sender keeps offering
		for (int i = 0; i < 80; i++)
			pending_reqs.push_back(rand_req());
		hold_off = 1'b1;
		wait (hold_left > 0);
		hold_off = 1'b0;
		while (pending_reqs.size() > 0)
			@(posedge clk);
		// pause until everything has drained
		while (expected_pins.size() > 0 || in_valid)
			@(posedge clk);
		// calm stretch with no idling
		calm = 1'b1;
		for (int i = 0; i < 150; i++)
			pending_reqs.push_back(rand_req());
		while (pending_reqs.size() > 0)
			@(posedge clk);
		calm = 1'b0;
		for (int i = 0; i < 600; i++)
			pending_reqs.push_back(rand_req());
		while (pending_reqs.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_pins.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		$display("checked %0d PINs: %0d fallback, %0d with every candidate weak",
			results_seen, fallbacks_seen, weak_seen);
		if (mismatches == 0 && expected_pins.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
